/* rtl/core/assert_macros.svh */
// Assertion macros for the core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clk edge out of reset.
`define COCS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clk edge out of reset.
`define COCS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/cocs_pkg.sv */
// Types, constants and elaboration-time functions of the paper/onion compositor.
package cocs_pkg;

  localparam int COORD_W  = 16;
  localparam int LIN_W    = 12;
  localparam int WIDE_W   = 13;
  localparam int SUM_W    = 14;
  localparam int PROD_W   = 25;
  localparam int CODE_W   = 8;
  localparam int CODE_N   = 256;
  localparam int THRESH_W = 13;
  localparam int CHAN_N   = 3;

  localparam logic [LIN_W-1:0] LIN_ONE    = 12'd4095;
  localparam logic [LIN_W-1:0] DARK_SHADE = 12'd3194;

  // x / 4095 for x < 2**25 as (x * DIV_RECIP) >> DIV_SHIFT, exact over that range
  localparam logic [PROD_W-1:0] ROUND_HALF = 25'd2047;
  localparam int DIV_SHIFT = 37;
  localparam int RECIP_W   = 26;
  localparam logic [RECIP_W-1:0] DIV_RECIP =
    26'(((64'd1 << DIV_SHIFT) + 64'd4094) / 64'd4095);

  typedef struct packed {
    logic signed [COORD_W-1:0] pixel_x;
    logic signed [COORD_W-1:0] pixel_y;
    logic [LIN_W-1:0]          src_red;
    logic [LIN_W-1:0]          src_green;
    logic [LIN_W-1:0]          src_blue;
    logic [LIN_W-1:0]          src_alpha;
    logic                      onion_present;
    logic [LIN_W-1:0]          onion_red;
    logic [LIN_W-1:0]          onion_green;
    logic [LIN_W-1:0]          onion_blue;
    logic [LIN_W-1:0]          onion_alpha;
  } in_word_t;

  typedef struct packed {
    logic [CODE_W-1:0] out_red;
    logic [CODE_W-1:0] out_green;
    logic [CODE_W-1:0] out_blue;
  } out_word_t;

  typedef struct packed {
    logic [LIN_W-1:0] red;
    logic [LIN_W-1:0] green;
    logic [LIN_W-1:0] blue;
    logic [LIN_W-1:0] alpha;
  } rgba_t;

  typedef struct packed {
    logic [LIN_W-1:0] red;
    logic [LIN_W-1:0] green;
    logic [LIN_W-1:0] blue;
  } lin_rgb_t;

  // entry b: smallest linear level that encodes to byte b or above (4096: never)
  typedef logic [CODE_N-1:0][THRESH_W-1:0] thresh_tab_t;

  function automatic logic [255:0] big_pow(logic [255:0] base, int unsigned e);
    logic [255:0] acc;
    acc = 256'd1;
    for (int unsigned k = 0; k < e; k++) acc = acc * base;
    return acc;
  endfunction

  // Exact check of round(255 * E(idx / dm1)) >= b, with integer arithmetic only.
  function automatic bit srgb_reaches(longint unsigned idx, longint unsigned b,
                                      longint unsigned dm1);
    bit           lin_part;
    logic [255:0] lhs;
    logic [255:0] rhs;
    lin_part = (idx * 64'd10000000) <= (64'd31308 * dm1);
    if (lin_part) return (idx * 64'd32946) >= ((64'd2 * b - 64'd1) * dm1 * 64'd5);
    lhs = big_pow(256'd10761, 12) * big_pow(256'(idx), 5);
    rhs = big_pow(256'(64'd40 * b + 64'd541), 12) * big_pow(256'(dm1), 5);
    return lhs >= rhs;
  endfunction

  function automatic thresh_tab_t srgb_thresholds(int unsigned depth);
    thresh_tab_t     tab;
    longint unsigned dm1;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    longint unsigned idx;
    dm1 = longint'(depth) - 64'd1;
    tab = '0;
    for (int b = 1; b < CODE_N; b++) begin
      lo = 0;
      hi = 64'd4096;
      while (lo < hi) begin
        mid = (lo + hi) / 2;
        idx = (mid * dm1 * 64'd2 + 64'd4095) / 64'd8190;
        if (srgb_reaches(idx, longint'(b), dm1)) hi = mid;
        else lo = mid + 64'd1;
      end
      tab[b] = THRESH_W'(lo);
    end
    return tab;
  endfunction

endpackage

/* rtl/core/cocs_word_if.sv */
// Valid/ready channel carrying one word of a given type.
interface cocs_word_if #(parameter type word_t = logic);
  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/cocs_mulround.sv */
// Two-stage rounded product a * b / 4095 (halves up) by reciprocal multiply.
module cocs_mulround (
  input  logic                          clk,
  input  logic                          en,
  input  logic [cocs_pkg::WIDE_W-1:0]   a,
  input  logic [cocs_pkg::LIN_W-1:0]    b,
  output logic [cocs_pkg::WIDE_W-1:0]   q
);

  localparam int FULL_W = cocs_pkg::PROD_W + cocs_pkg::RECIP_W;

  logic [cocs_pkg::PROD_W-1:0] prod_r;
  logic [cocs_pkg::PROD_W-1:0] biased;
  logic [FULL_W-1:0]           scaled;
  logic [cocs_pkg::WIDE_W-1:0] q_r;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= cocs_pkg::PROD_W'(a) * cocs_pkg::PROD_W'(b);
    end
  end

  // floor((2p + 4095) / 8190) equals floor((p + 2047) / 4095)
  assign biased = prod_r + cocs_pkg::ROUND_HALF;
  assign scaled = FULL_W'(biased) * FULL_W'(cocs_pkg::DIV_RECIP);

  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= scaled[cocs_pkg::DIV_SHIFT +: cocs_pkg::WIDE_W];
    end
  end

  assign q = q_r;

endmodule

/* rtl/core/cocs_srgb_enc.sv */
// Eight-stage sRGB encoder: binary search of a byte threshold table, three lanes.
module cocs_srgb_enc #(
  parameter int SRGB_TABLE_DEPTH = 4096
) (
  input  logic                          clk,
  input  logic                          en,
  input  cocs_pkg::lin_rgb_t            lin,
  output cocs_pkg::out_word_t           code
);

  localparam int STEPS = cocs_pkg::CODE_W;
  localparam cocs_pkg::thresh_tab_t THRESH =
    cocs_pkg::srgb_thresholds(SRGB_TABLE_DEPTH);

  logic [cocs_pkg::LIN_W-1:0]  lin_vec [cocs_pkg::CHAN_N];
  logic [cocs_pkg::LIN_W-1:0]  lin_r   [STEPS-1][cocs_pkg::CHAN_N];
  logic [cocs_pkg::CODE_W-1:0] code_r  [STEPS][cocs_pkg::CHAN_N];

  assign lin_vec[0] = lin.red;
  assign lin_vec[1] = lin.green;
  assign lin_vec[2] = lin.blue;

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    for (genvar c = 0; c < cocs_pkg::CHAN_N; c++) begin : g_lane
      logic [cocs_pkg::LIN_W-1:0]  lvl;
      logic [cocs_pkg::CODE_W-1:0] base;
      logic [cocs_pkg::CODE_W-1:0] cand;

      if (k == 0) begin : g_first
        assign lvl  = lin_vec[c];
        assign base = '0;
      end else begin : g_next
        assign lvl  = lin_r[k-1][c];
        assign base = code_r[k-1][c];
      end

      // try the next lower bit of the code; keep it if its threshold is met
      assign cand = base | cocs_pkg::CODE_W'(1 << (STEPS - 1 - k));

      always_ff @(posedge clk) begin
        if (en) begin
          code_r[k][c] <= (THRESH[cand] <= {1'b0, lvl}) ? cand : base;
        end
      end

      if (k < STEPS - 1) begin : g_carry
        always_ff @(posedge clk) begin
          if (en) begin
            lin_r[k][c] <= lvl;
          end
        end
      end
    end
  end

  assign code.out_red   = code_r[STEPS-1][0];
  assign code.out_green = code_r[STEPS-1][1];
  assign code.out_blue  = code_r[STEPS-1][2];

endmodule

/* rtl/core/checker_onion_composite_srgb_unit.sv */
// Top level: paper, onion-over-paper, drawing-over-onion, sRGB encode pipeline.
//
//   channel   dir   word                                      handshake
//   in_chan   in    pixel_x/y, src rgba, onion flag + rgba    valid/ready
//   out_chan  out   out_red, out_green, out_blue bytes        valid/ready
//   cfg_chan  in    checker_enable (1 bit)                    valid/ready, always ready
//
// One word per cycle sustained while out_chan takes results; the path from accept to
// out_chan.valid is 9 arithmetic stages, then 8 stages of threshold search in the encoder.
// All stages advance together; when a result waits untaken the whole pipe holds.
// rst_n clears the valid bits and sets checker_enable; the encoder table is
// a constant, so there is no start-up sweep.
`include "assert_macros.svh"

module checker_onion_composite_srgb_unit #(
  parameter int CHECKER_CELL     = 8,
  parameter int SRGB_TABLE_DEPTH = 4096
) (
  input  logic       clk,
  input  logic       rst_n,
  cocs_word_if.sink   in_chan,
  cocs_word_if.source out_chan,
  cocs_word_if.sink   cfg_chan
);

  localparam int STAGES = 9 + cocs_pkg::CODE_W;
  localparam int CW     = cocs_pkg::COORD_W;
  localparam int LW     = cocs_pkg::LIN_W;
  localparam int WW     = cocs_pkg::WIDE_W;
  localparam int NCH    = cocs_pkg::CHAN_N;

  // |p| / CHECKER_CELL as (|p| * CELL_RECIP) >> CELL_SHIFT, exact for |p| < 2**16
  localparam int CELL_LOG   = $clog2(CHECKER_CELL);
  localparam int CELL_SHIFT = CW + CELL_LOG;
  localparam longint unsigned CELL_RECIP =
    ((64'd1 << CELL_SHIFT) + 64'(CHECKER_CELL) - 64'd1) / 64'(CHECKER_CELL);
  localparam int CELL_RECIP_W = $clog2(CELL_RECIP + 64'd1);
  localparam int CELL_PROD_W  = CW + CELL_RECIP_W;

  logic                pipe_en;
  logic                in_fire;
  logic [STAGES:1]     vld_r;
  logic                chk_r;

  logic [CW-1:0]       ax_nxt;
  logic [CW-1:0]       ay_nxt;
  cocs_pkg::rgba_t     onion_nxt;

  logic [CW-1:0]       s1_ax_r;
  logic [CW-1:0]       s1_ay_r;
  logic                s1_chk_r;
  cocs_pkg::rgba_t     s1_src_r;
  cocs_pkg::rgba_t     s1_onion_r;

  logic [CELL_PROD_W-1:0] qx_prod;
  logic [CELL_PROD_W-1:0] qy_prod;

  logic                s2_par_r;
  logic                s2_chk_r;
  cocs_pkg::rgba_t     s2_src_r;
  cocs_pkg::rgba_t     s2_onion_r;

  logic [LW-1:0]       s3_paper_r;
  logic [LW-1:0]       s3_oa_inv_r;
  cocs_pkg::rgba_t     s3_src_r;
  cocs_pkg::rgba_t     s3_onion_r;

  cocs_pkg::rgba_t     s4_src_r;
  cocs_pkg::rgba_t     s4_onion_r;
  cocs_pkg::rgba_t     s5_src_r;
  cocs_pkg::rgba_t     s5_onion_r;

  logic [WW-1:0]       paper_q;
  logic [LW-1:0]       onion_ch [NCH];
  logic [WW-1:0]       s6_bot_r [NCH];
  logic [LW-1:0]       s6_sa_inv_r;
  cocs_pkg::rgba_t     s6_src_r;

  logic [WW-1:0]       over_q [NCH];
  cocs_pkg::rgba_t     s7_src_r;
  cocs_pkg::rgba_t     s8_src_r;
  logic [LW-1:0]       src_ch [NCH];
  logic [LW-1:0]       lin_nxt [NCH];
  cocs_pkg::lin_rgb_t  s9_lin_r;

  // configuration
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chk_r <= 1'b1;
    end else if (cfg_chan.valid) begin
      chk_r <= cfg_chan.data;
    end
  end

  // pipe control: advance whenever the output slot is free or being taken
  assign pipe_en       = !vld_r[STAGES] || out_chan.ready;
  assign in_chan.ready = pipe_en;
  assign in_fire       = in_chan.valid && pipe_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (pipe_en) begin
      vld_r <= {vld_r[STAGES-1:1], in_fire};
    end
  end

  // stage 1: magnitudes of the coordinates, drop an absent onion to transparent
  assign ax_nxt = in_chan.data.pixel_x[CW-1] ? CW'(-in_chan.data.pixel_x)
                                             : in_chan.data.pixel_x;
  assign ay_nxt = in_chan.data.pixel_y[CW-1] ? CW'(-in_chan.data.pixel_y)
                                             : in_chan.data.pixel_y;
  assign onion_nxt = in_chan.data.onion_present
                   ? {in_chan.data.onion_red, in_chan.data.onion_green,
                      in_chan.data.onion_blue, in_chan.data.onion_alpha}
                   : '0;

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s1_ax_r    <= ax_nxt;
      s1_ay_r    <= ay_nxt;
      s1_chk_r   <= chk_r;
      s1_src_r   <= {in_chan.data.src_red, in_chan.data.src_green,
                     in_chan.data.src_blue, in_chan.data.src_alpha};
      s1_onion_r <= onion_nxt;
    end
  end

  // stage 2: cell index parity; truncating division keeps the parity of |q|
  assign qx_prod = CELL_PROD_W'(s1_ax_r) * CELL_PROD_W'(CELL_RECIP);
  assign qy_prod = CELL_PROD_W'(s1_ay_r) * CELL_PROD_W'(CELL_RECIP);

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s2_par_r   <= qx_prod[CELL_SHIFT] ^ qy_prod[CELL_SHIFT];
      s2_chk_r   <= s1_chk_r;
      s2_src_r   <= s1_src_r;
      s2_onion_r <= s1_onion_r;
    end
  end

  // stage 3: paper shade
  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s3_paper_r  <= (s2_chk_r && s2_par_r) ? cocs_pkg::DARK_SHADE : cocs_pkg::LIN_ONE;
      s3_oa_inv_r <= cocs_pkg::LIN_ONE - s2_onion_r.alpha;
      s3_src_r    <= s2_src_r;
      s3_onion_r  <= s2_onion_r;
    end
  end

  // stages 4-5: paper under the onion, same for all three channels
  cocs_mulround u_paper_mul (
    .clk (clk),
    .en  (pipe_en),
    .a   ({1'b0, s3_paper_r}),
    .b   (s3_oa_inv_r),
    .q   (paper_q)
  );

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s4_src_r   <= s3_src_r;
      s4_onion_r <= s3_onion_r;
      s5_src_r   <= s4_src_r;
      s5_onion_r <= s4_onion_r;
    end
  end

  // stage 6: onion over paper, kept wide
  assign onion_ch[0] = s5_onion_r.red;
  assign onion_ch[1] = s5_onion_r.green;
  assign onion_ch[2] = s5_onion_r.blue;

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      for (int c = 0; c < NCH; c++) begin
        s6_bot_r[c] <= WW'(onion_ch[c]) + paper_q;
      end
      s6_sa_inv_r <= cocs_pkg::LIN_ONE - s5_src_r.alpha;
      s6_src_r    <= s5_src_r;
    end
  end

  // stages 7-8: backdrop under the drawing
  for (genvar c = 0; c < NCH; c++) begin : g_over
    cocs_mulround u_over_mul (
      .clk (clk),
      .en  (pipe_en),
      .a   (s6_bot_r[c]),
      .b   (s6_sa_inv_r),
      .q   (over_q[c])
    );
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s7_src_r <= s6_src_r;
      s8_src_r <= s7_src_r;
    end
  end

  // stage 9: drawing over backdrop, clamp to full scale
  assign src_ch[0] = s8_src_r.red;
  assign src_ch[1] = s8_src_r.green;
  assign src_ch[2] = s8_src_r.blue;

  for (genvar c = 0; c < NCH; c++) begin : g_sum
    logic [cocs_pkg::SUM_W-1:0] sum;
    assign sum        = cocs_pkg::SUM_W'(src_ch[c]) + cocs_pkg::SUM_W'(over_q[c]);
    assign lin_nxt[c] = (sum > cocs_pkg::SUM_W'(cocs_pkg::LIN_ONE)) ? cocs_pkg::LIN_ONE
                                                                  : sum[LW-1:0];
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s9_lin_r <= {lin_nxt[0], lin_nxt[1], lin_nxt[2]};
    end
  end

  // stages 10-17: encode; the last search stage is the output register
  cocs_srgb_enc #(
    .SRGB_TABLE_DEPTH (SRGB_TABLE_DEPTH)
  ) u_enc (
    .clk  (clk),
    .en   (pipe_en),
    .lin  (s9_lin_r),
    .code (out_chan.data)
  );

  assign out_chan.valid = vld_r[STAGES];

  `COCS_ASSERT_NXT(a_stall_holds_valids, !pipe_en, $stable(vld_r), "valid bits moved while stalled")
  `COCS_ASSERT_NXT(a_flat_paper, pipe_en && vld_r[2] && !s2_chk_r, s3_paper_r == cocs_pkg::LIN_ONE, "flat paper not white")
  `COCS_ASSERT_IMP(a_backdrop_range, vld_r[6], s6_bot_r[0] <= WW'(8190) && s6_bot_r[1] <= WW'(8190) && s6_bot_r[2] <= WW'(8190), "onion over paper out of range")

endmodule
